[design/assert_macros.svh]
// Assertion macros shared by the range prefix cover RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside of reset.
`define RPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/rpc_pkg.sv]
// Shared types and constants of the range prefix cover block.
// No dependencies; imported by the front, walker and top level.
package rpc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int LEN_W           = 6;
  localparam int SPARS_W         = 4;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int MAX_PIECES      = 64;
  localparam int CNT_W           = 7;
  localparam int CMD_DEPTH       = 2;
  localparam int RES_DEPTH       = 2;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ORDER  = 2'd1,
    ERR_DOMAIN = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN_MAX     = 1'b0,
    REG_LEVEL_SPARSITY = 1'b1
  } reg_idx_t;

  // Settings derived from the configuration registers
  typedef struct packed {
    logic [LEN_W-1:0]   max_len;
    logic [SPARS_W-1:0] sparsity;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [LEN_W-1:0]   length;
    err_t               err;
    logic               overflow;
    logic               last;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

[design/range_prefix_cover.sv]
// Top level of the range prefix cover block.
// Depends on rpc_pkg, rpc_front, rpc_fifo and rpc_walk.

// Splits each query range [range_low, range_high] into aligned binary prefix
// blocks, emitted in depth-first order, one result per block; the final result
// of a query has last set, and an invalid query yields a single result with an
// error code. Queries enter through a two-entry queue and results leave
// through another, so both sides may stall freely. One query is walked at a
// time: the walker spends a visit step on each tree node it visits and a
// separate pop step on each stack pop (the stack memory has a registered read
// port), plus fetch, setup and finish steps, and result stalls can hold it.
// Each emitted piece and each block that misses the range costs at most its
// split, its visit and its pop, and at most two blocks per tree level can
// miss; a query ends at the 64-piece limit. A domain_max write reaches the
// root depth in the cycle after it reaches the register, because the root
// depth is registered behind domain_max.
module range_prefix_cover #(
  parameter int VALUE_WIDTH = rpc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rpc_pkg::FIELD_W-1:0]   range_low,
  input  logic [rpc_pkg::FIELD_W-1:0]   range_high,
  output logic                          empty,
  input  logic                          pop,
  output logic [rpc_pkg::FIELD_W-1:0]   prefix_value,
  output logic [rpc_pkg::LEN_W-1:0]     prefix_length,
  output logic [1:0]                    error_code,
  output logic                          overflow,
  output logic                          last,
  input  logic                          cfg_wr_en,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rpc_pkg::CFG_W-1:0]     cfg_wdata
);

  import rpc_pkg::*;

  localparam int DW    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int CMD_W = 2 * DW + 2;

  cfg_t             cfg;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  result_t          res_in;
  result_t          res_out;

  // Accept and classify queries
  rpc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .range_low  (range_low),
    .range_high (range_high),
    .cfg        (cfg),
    .cmd_data   (cmd_in)
  );

  // Queue classified queries ahead of the walker
  rpc_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Walk the prefix tree
  rpc_walk #(.VALUE_WIDTH(VALUE_WIDTH)) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Hold results until taken
  rpc_fifo #(.WIDTH(RESULT_W), .DEPTH(RES_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign prefix_value  = res_out.value;
  assign prefix_length = res_out.length;
  assign error_code    = res_out.err;
  assign overflow      = res_out.overflow;
  assign last          = res_out.last;

endmodule

[design/rpc_fifo.sv]
// Small first-in first-out queue of registers, used between the stages.
// Depends on assert_macros.svh; DEPTH must be a power of two, at least 2.
`include "assert_macros.svh"

module rpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store an accepted request
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  `RPC_NEVER(a_count_bound, (count > CW'(DEPTH)), "queue occupancy beyond depth")
  `RPC_ASSERT(a_ptr_gap, ((wr_ptr - rd_ptr) == PW'(count)), "queue pointers disagree with count")
  `RPC_ASSERT(a_full_hold, ((full && !rd_en) |=> full), "queue lost an entry while full")

endmodule

[design/rpc_front.sv]
// Front stage: configuration registers, root depth encoder and query check.
// Depends on rpc_pkg.
module rpc_front #(
  parameter int  VALUE_WIDTH = rpc_pkg::VALUE_WIDTH_DEF,
  localparam int DW          = (VALUE_WIDTH < rpc_pkg::FIELD_W) ? VALUE_WIDTH : rpc_pkg::FIELD_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rpc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [rpc_pkg::FIELD_W-1:0]   range_low,
  input  logic [rpc_pkg::FIELD_W-1:0]   range_high,
  output rpc_pkg::cfg_t                 cfg,
  output logic [2*DW+1:0]               cmd_data
);

  import rpc_pkg::*;

  localparam int NB = (DW + 7) / 8;

  logic [DW-1:0]      dmax;
  logic [SPARS_W-1:0] spars;
  logic [LEN_W-1:0]   max_len;
  logic [LEN_W-1:0]   blen;
  logic [NB*8-1:0]    dpad;
  logic [3:0]         byte_len [NB];
  logic [DW-1:0]      lo;
  logic [DW-1:0]      hi;
  err_t               err;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dmax  <= '1;
      spars <= SPARS_W'(1);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_DOMAIN_MAX:     dmax  <= cfg_wdata[DW-1:0];
        REG_LEVEL_SPARSITY: spars <= cfg_wdata[SPARS_W-1:0];
      endcase
    end
  end

  // Bit length of the domain maximum: per byte, then highest nonzero byte
  always_comb begin
    dpad = (NB*8)'(dmax);
    for (int b = 0; b < NB; b++) begin
      byte_len[b] = '0;
      for (int i = 0; i < 8; i++) begin
        if (dpad[b*8+i]) begin
          byte_len[b] = 4'(i + 1);
        end
      end
    end
    blen = '0;
    for (int b = 0; b < NB; b++) begin
      if (byte_len[b] != '0) begin
        blen = LEN_W'(b * 8) + LEN_W'(byte_len[b]);
      end
    end
  end

  // Register the root depth behind the domain maximum register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_W'(DW);
    end else begin
      max_len <= blen;
    end
  end

  assign cfg.max_len  = max_len;
  assign cfg.sparsity = (spars == '0) ? SPARS_W'(1) : spars;

  // Classify the query: order check first, then the domain bound
  assign lo = range_low[DW-1:0];
  assign hi = range_high[DW-1:0];

  always_comb begin
    if (lo > hi) begin
      err = ERR_ORDER;
    end else if (hi > dmax) begin
      err = ERR_DOMAIN;
    end else begin
      err = ERR_NONE;
    end
  end

  assign cmd_data = {lo, hi, err};

endmodule

[design/rpc_walk.sv]
// Back stage: depth-first prefix walk with a stack memory of right siblings.
// Depends on rpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpc_walk #(
  parameter int  VALUE_WIDTH = rpc_pkg::VALUE_WIDTH_DEF,
  localparam int DW          = (VALUE_WIDTH < rpc_pkg::FIELD_W) ? VALUE_WIDTH : rpc_pkg::FIELD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  rpc_pkg::cfg_t     cfg,
  input  logic [2*DW+1:0]   cmd_data,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output rpc_pkg::result_t  res_data
);

  import rpc_pkg::*;

  localparam int AW   = $clog2(DW);
  localparam int SP_W = $clog2(DW + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_VISIT  = 5'b00100,
    S_POP    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic [DW-1:0]      start;
    logic [LEN_W-1:0]   bits;
    logic [SPARS_W-1:0] lmod;
  } entry_t;

  state_t             state;
  logic [DW-1:0]      lo;
  logic [DW-1:0]      hi;
  err_t               err;
  logic [DW-1:0]      cur_start;
  logic [LEN_W-1:0]   cur_bits;
  logic [SPARS_W-1:0] cur_mod;
  logic [SP_W-1:0]    sp;
  logic [SP_W-1:0]    sp_m1;
  logic [CNT_W-1:0]   count;
  result_t            held;
  logic               held_valid;
  logic               ovf;

  entry_t             stack_mem [DW];
  entry_t             rd_q;
  entry_t             stk_wdata;
  logic               stk_we;
  logic [AW-1:0]      rd_addr;

  logic [DW-1:0]      mask;
  logic [DW-1:0]      cur_end;
  logic               disjoint;
  logic               covered;
  logic               lvl_ok;
  logic               take;
  logic               descend;
  logic               at_limit;
  logic [LEN_W-1:0]   bits_m1;
  logic [SPARS_W-1:0] mod_inc;
  logic [SPARS_W-1:0] mod_n;
  result_t            piece;
  state_t             after;

  // Examine the current block
  assign mask     = ~({DW{1'b1}} << cur_bits);
  assign cur_end  = cur_start | mask;
  assign disjoint = (cur_end < lo) || (cur_start > hi);
  assign covered  = (cur_start >= lo) && (cur_end <= hi);
  assign lvl_ok   = (cur_bits == '0) || (cur_bits == cfg.max_len) || (cur_mod == '0);
  assign take     = !disjoint && covered && lvl_ok;
  assign descend  = !disjoint && !take && (cur_bits != '0);
  assign at_limit = (count == CNT_W'(MAX_PIECES));
  assign bits_m1  = cur_bits - LEN_W'(1);
  assign mod_inc  = cur_mod + SPARS_W'(1);
  assign mod_n    = (mod_inc == cfg.sparsity) ? '0 : mod_inc;
  assign after    = (sp == '0) ? S_FINISH : S_POP;

  assign piece.value    = FIELD_W'(cur_start >> cur_bits);
  assign piece.length   = cfg.max_len - cur_bits;
  assign piece.err      = ERR_NONE;
  assign piece.overflow = 1'b0;
  assign piece.last     = 1'b0;

  // Push the right sibling when splitting
  assign stk_we          = (state == S_VISIT) && descend;
  assign stk_wdata.start = cur_start | (DW'(1) << bits_m1);
  assign stk_wdata.bits  = bits_m1;
  assign stk_wdata.lmod  = mod_n;
  assign sp_m1           = sp - SP_W'(1);
  assign rd_addr         = sp_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[sp[AW-1:0]] <= stk_wdata;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;

  // Drive result requests
  always_comb begin
    res_push = 1'b0;
    res_data = held;
    unique case (state)
      S_START: begin
        res_push = (err != ERR_NONE) && !res_full;
        res_data = '{value: '0, length: '0, err: err, overflow: 1'b0, last: 1'b1};
      end
      S_VISIT: begin
        res_push = take && !at_limit && held_valid && !res_full;
      end
      S_FINISH: begin
        res_push = !res_full;
        if (held_valid) begin
          res_data.overflow = ovf;
          res_data.last     = 1'b1;
        end else begin
          res_data = '{value: '0, length: '0, err: ERR_NONE, overflow: 1'b0, last: 1'b1};
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // Sequence the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sp         <= '0;
      count      <= '0;
      held_valid <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            lo    <= cmd_data[2*DW+1 -: DW];
            hi    <= cmd_data[DW+1 -: DW];
            err   <= err_t'(cmd_data[1:0]);
            state <= S_START;
          end
        end
        S_START: begin
          if (err != ERR_NONE) begin
            if (!res_full) begin
              state <= S_IDLE;
            end
          end else begin
            cur_start  <= '0;
            cur_bits   <= cfg.max_len;
            cur_mod    <= '0;
            sp         <= '0;
            count      <= '0;
            held_valid <= 1'b0;
            ovf        <= 1'b0;
            state      <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (disjoint) begin
            state <= after;
          end else if (take) begin
            if (at_limit) begin
              ovf   <= 1'b1;
              state <= S_FINISH;
            end else if (!(held_valid && res_full)) begin
              held       <= piece;
              held_valid <= 1'b1;
              count      <= count + CNT_W'(1);
              state      <= after;
            end
          end else if (cur_bits == '0) begin
            state <= after;
          end else begin
            sp       <= sp + SP_W'(1);
            cur_bits <= bits_m1;
            cur_mod  <= mod_n;
          end
        end
        S_POP: begin
          cur_start <= rd_q.start;
          cur_bits  <= rd_q.bits;
          cur_mod   <= rd_q.lmod;
          sp        <= sp_m1;
          state     <= S_VISIT;
        end
        S_FINISH: begin
          if (!res_full) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RPC_NEVER(a_sp_bound, (sp > SP_W'(DW)), "stack pointer beyond stack depth")
  `RPC_NEVER(a_count_bound, (count > CNT_W'(MAX_PIECES)), "piece count beyond limit")
  `RPC_ASSERT(a_push_room, (res_push |-> !res_full), "result pushed into a full queue")
  `RPC_ASSERT(a_idle_clean, ((state == S_IDLE) |-> !held_valid), "piece left over after query")

endmodule
